// ----- rtl/cjm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cjm_pkg: shared types and constants of the conference jitter mixer
// Payload structs of the item, result and configuration channels, fill mode
// codes and the saturating-style mixing function.
// ----------------------------------------------------------------------------
package cjm_pkg;

	// default geometry of the ring
	localparam int DEF_SLOTS         = 16;
	localparam int DEF_FRAME_SAMPLES = 160;

	// depth of the queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;

	// high water register
	localparam logic [6:0]  HW_RESET     = 7'd10;
	localparam logic [15:0] PERCENT_FULL = 16'd100;

	// opcode values
	localparam logic OP_POST = 1'b0;
	localparam logic OP_READ = 1'b1;

	// mixing divisor pieces, 32767 = 2^15 - 1
	localparam logic [16:0] MIX_DIV    = 17'd32767;
	localparam logic [16:0] MIX_DIV_X2 = 17'd65534;

	// fill state machine
	typedef enum logic [4:0] {
		MODE_START      = 5'b00001,
		MODE_BUFFERING  = 5'b00010,
		MODE_HIGH_WATER = 5'b00100,
		MODE_BUFFERED   = 5'b01000,
		MODE_RESEQUENCE = 5'b10000
	} mode_t;

	// input item
	typedef struct packed {
		logic               opcode;
		logic signed [15:0] sample;
		logic [7:0]         position;
		logic               use_write_slot;
		logic [15:0]        seq;
	} item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic               opcode;
		logic signed [15:0] sample;
		logic [7:0]         position;
		logic               use_write_slot;
		logic [15:0]        seq;
		logic               in_range;
		logic               is_last;
		logic               pos_zero;
	} work_t;

	// result item
	typedef struct packed {
		logic signed [15:0] out_sample;
		logic [3:0]         slot;
		logic               silent;
		logic               rejected;
		logic               last;
	} result_t;

	// configuration write
	typedef struct packed {
		logic [6:0] high_water_percent;
	} cfg_t;

	// mix stored sample a with posted sample b, prod = a*b
	// prod/32767 by shift and fold: q0 = p>>15, remainder r = (p mod 2^15) + q0 < 2*32767+2
	function automatic logic signed [15:0] mix_sample(
		input logic signed [15:0] a,
		input logic signed [15:0] b,
		input logic signed [31:0] prod
	);
		logic [30:0]        mag;
		logic [15:0]        q0;
		logic [16:0]        rem;
		logic [16:0]        quo;
		logic signed [17:0] sum;
		logic signed [17:0] res;
		mag = prod[30:0];
		q0  = mag[30:15];
		rem = 17'(mag[14:0]) + 17'(q0);
		quo = 17'(q0) + 17'(rem >= MIX_DIV) + 17'(rem >= MIX_DIV_X2);
		sum = 18'(a) + 18'(b);
		if (b == '0) begin
			res = 18'(a);
		end else if (a == '0) begin
			res = 18'(b);
		end else if (a[15] && b[15]) begin
			res = sum + $signed({1'b0, quo});
		end else if (!a[15] && !b[15]) begin
			res = sum - $signed({1'b0, quo});
		end else begin
			res = sum;
		end
		return res[15:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/cjm_chan_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cjm_chan_if: valid/ready channel
// Carries one payload of type T per transfer between a source and a sink.
// ----------------------------------------------------------------------------
interface cjm_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/conference_jitter_mixer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// conference_jitter_mixer_unit: mixing jitter buffer for conference audio
// Ring of frame slots that mixes posted samples and plays them out per read.
// ----------------------------------------------------------------------------
// Items enter through a front stage and a two-entry queue, so intake goes on
// while the back end works and while a result waits to be taken. The back end
// handles one item at a time: a rejected post, a silent read or an out of
// range position finishes straight from idle, a played read takes a frame
// memory read, then a clear of the sample, and a mixed post takes a memory
// read, a 16x16 multiply, then a mix and write back; the read-modify-write of
// the frame memory sets this pace. After reset, and after each resequence of
// the ring, the frame memory of SLOTS*FRAME_SAMPLES samples (2560 with the
// defaults) is cleared one sample per cycle, during which queued items wait.
// The high water register may be written at any time the block is idle; a new
// value applies from the next fill decision at a read at position zero.
module conference_jitter_mixer_unit #(
	parameter int SLOTS         = cjm_pkg::DEF_SLOTS,
	parameter int FRAME_SAMPLES = cjm_pkg::DEF_FRAME_SAMPLES
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cjm_chan_if.sink   item,
	cjm_chan_if.sink   cfg,
	cjm_chan_if.source result
);
	import cjm_pkg::*;

	cjm_chan_if #(.T(work_t)) front_ch ();
	cjm_chan_if #(.T(work_t)) queue_ch ();

	// classify incoming items
	cjm_front #(
		.FRAME_SAMPLES(FRAME_SAMPLES)
	) u_front (
		.item (item),
		.work (front_ch.source)
	);

	// decouple intake from execution
	cjm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_ch.sink),
		.pop    (queue_ch.source)
	);

	// ring state, memory and mixer
	cjm_back #(
		.SLOTS        (SLOTS),
		.FRAME_SAMPLES(FRAME_SAMPLES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.work   (queue_ch.sink),
		.cfg    (cfg),
		.result (result)
	);

`ifndef SYNTH
	// a result is never both silent and rejected
	a_silent_or_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.data.silent && result.data.rejected))
		else $error("result flagged both silent and rejected");

	// silent reads and refused posts carry no sample
	a_no_sample_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.data.silent || result.data.rejected)
		|-> result.data.out_sample == '0)
		else $error("silent or rejected result carries a sample");

	// last position is always inside the frame
	a_last_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		queue_ch.valid |-> (!queue_ch.data.is_last || queue_ch.data.in_range))
		else $error("queued item marked last but out of range");
`endif

endmodule
`default_nettype wire

// ----- rtl/cjm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cjm_front: item intake and classification
// Tags each incoming item with its frame position class before it is queued.
// ----------------------------------------------------------------------------
module cjm_front #(
	parameter int FRAME_SAMPLES = cjm_pkg::DEF_FRAME_SAMPLES
) (
	cjm_chan_if.sink   item,
	cjm_chan_if.source work
);
	import cjm_pkg::*;

	localparam int LAST_POS = FRAME_SAMPLES - 1;

	work_t w;

	// handshake passes straight to the queue
	assign work.valid = item.valid;
	assign item.ready = work.ready;

	// position classification
	always_comb begin
		w.opcode         = item.data.opcode;
		w.sample         = item.data.sample;
		w.position       = item.data.position;
		w.use_write_slot = item.data.use_write_slot;
		w.seq            = item.data.seq;
		w.in_range       = int'(item.data.position) < FRAME_SAMPLES;
		w.is_last        = int'(item.data.position) == LAST_POS;
		w.pos_zero       = item.data.position == '0;
	end

	assign work.data = w;

endmodule
`default_nettype wire

// ----- rtl/cjm_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cjm_queue: work queue between front and back
// Small register queue so that intake keeps going while the back is busy.
// ----------------------------------------------------------------------------
module cjm_queue (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cjm_chan_if.sink   push,
	cjm_chan_if.source pop
);
	import cjm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	work_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_xfer;
	logic             pop_xfer;

	assign push.ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop.valid  = count_q != '0;
	assign pop.data   = entry_q[rptr_q];
	assign push_xfer  = push.valid && push.ready;
	assign pop_xfer   = pop.valid && pop.ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_xfer) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop_xfer) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push_xfer && !pop_xfer) begin
				count_q <= count_q + 1'b1;
			end else if (pop_xfer && !push_xfer) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_xfer) begin
			entry_q[wptr_q] <= push.data;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cjm_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cjm_back: ring state, frame memory and mixer
// Runs the fill state machine, the per-frame latches and slot bookkeeping,
// and does read-modify-write of the frame memory for mixing and playout.
// ----------------------------------------------------------------------------
module cjm_back #(
	parameter int SLOTS         = cjm_pkg::DEF_SLOTS,
	parameter int FRAME_SAMPLES = cjm_pkg::DEF_FRAME_SAMPLES
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cjm_chan_if.sink   work,
	cjm_chan_if.sink   cfg,
	cjm_chan_if.source result
);
	import cjm_pkg::*;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int DEPTH  = SLOTS * FRAME_SAMPLES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_MEM   = 4'b0100,
		ST_MIX   = 4'b1000
	} back_state_t;

	// control state
	back_state_t       state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	mode_t             fill_mode_q;
	logic [SLOTS-1:0]  slot_filled_q;
	logic [SLOT_W-1:0] filled_count_q;
	logic [SLOT_W-1:0] read_slot_q;
	logic [SLOT_W-1:0] write_slot_q;
	logic              latch_reject_q;
	logic              latch_play_q;
	logic [6:0]        hw_q;
	logic              out_valid_q;

	// item payload held while the memory is worked on
	logic               op_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [ADDR_W-1:0]  addr_q;
	logic signed [15:0] b_q;
	logic               last_q;
	result_t            out_q;

	// memory and mixer pipeline
	logic [15:0]        mem_q [DEPTH];
	logic signed [15:0] rdata_s1;
	logic signed [15:0] a_s2;
	logic signed [31:0] prod_s2;

	// decode of the item at the head of the queue
	work_t              e;
	logic               out_free;
	logic               take;
	logic               is_post;
	logic [SLOT_W-1:0]  post_slot;
	logic               post_rej;
	mode_t              fill_next;
	logic               reseq_now;
	logic               play_new;
	logic               read_play;
	logic [SLOT_W-1:0]  use_slot;
	logic [ADDR_W-1:0]  item_addr;
	logic [15:0]        scaled_fill;
	logic [15:0]        high_mark;

	// memory write port
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [15:0]        mem_wdata;
	logic signed [15:0] mix_val;

	assign e        = work.data;
	assign out_free = !out_valid_q || result.ready;
	assign work.ready = (state_q == ST_IDLE) && out_free;
	assign take     = work.valid && work.ready;
	assign cfg.ready = 1'b1;

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// fill state step taken at a read at position zero
	assign scaled_fill = 16'(filled_count_q) * PERCENT_FULL;
	assign high_mark   = 16'(hw_q) * 16'(SLOTS);

	always_comb begin
		fill_next = fill_mode_q;
		unique case (fill_mode_q)
			MODE_START: begin
				if (filled_count_q != '0) fill_next = MODE_BUFFERING;
			end
			MODE_BUFFERING: begin
				if (scaled_fill >= high_mark) fill_next = MODE_HIGH_WATER;
				else if (filled_count_q == '0) fill_next = MODE_RESEQUENCE;
			end
			MODE_HIGH_WATER: begin
				fill_next = MODE_BUFFERED;
			end
			MODE_BUFFERED: begin
				if (filled_count_q == '0) fill_next = MODE_RESEQUENCE;
			end
			MODE_RESEQUENCE: begin
				fill_next = MODE_START;
			end
			default: begin
				fill_next = fill_mode_q;
			end
		endcase
	end

	// item classification against the ring state
	always_comb begin
		is_post   = e.opcode == OP_POST;
		post_slot = e.use_write_slot ? write_slot_q : SLOT_W'(e.seq);
		post_rej  = !e.in_range ||
			(e.pos_zero ? (fill_mode_q == MODE_RESEQUENCE) : latch_reject_q);
		reseq_now = e.in_range && e.pos_zero && (fill_mode_q == MODE_RESEQUENCE);
		play_new  = (fill_next == MODE_HIGH_WATER) || (fill_next == MODE_BUFFERED);
		read_play = e.in_range && (e.pos_zero ? play_new : latch_play_q);
		use_slot  = is_post ? post_slot : (reseq_now ? '0 : read_slot_q);
		item_addr = ADDR_W'(use_slot) * ADDR_W'(FRAME_SAMPLES) + ADDR_W'(e.position);
	end

	// mixer result and memory write selection
	assign mix_val = mix_sample(a_s2, b_q, prod_s2);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		priority if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
		end else if (state_q == ST_MEM && op_q == OP_READ) begin
			mem_we = 1'b1;
		end else if (state_q == ST_MIX) begin
			mem_we    = 1'b1;
			mem_wdata = mix_val;
		end else begin
			mem_we = 1'b0;
		end
	end

	// control and ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_addr_q     <= '0;
			fill_mode_q    <= MODE_START;
			slot_filled_q  <= '0;
			filled_count_q <= '0;
			read_slot_q    <= '0;
			write_slot_q   <= SLOT_W'(SLOTS / 2);
			latch_reject_q <= 1'b0;
			latch_play_q   <= 1'b0;
			hw_q           <= HW_RESET;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				hw_q <= cfg.data.high_water_percent;
			end
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						clr_addr_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (take && is_post) begin
						out_valid_q <= 1'b1;
						if (e.in_range && e.pos_zero) begin
							latch_reject_q <= fill_mode_q == MODE_RESEQUENCE;
						end
						if (!post_rej && e.pos_zero && !slot_filled_q[post_slot]) begin
							slot_filled_q[post_slot] <= 1'b1;
							filled_count_q           <= filled_count_q + 1'b1;
						end
						state_q <= post_rej ? ST_IDLE : ST_MEM;
					end else if (take) begin
						if (e.in_range && e.pos_zero) begin
							fill_mode_q  <= fill_next;
							latch_play_q <= play_new;
						end
						if (reseq_now) begin
							read_slot_q    <= '0;
							write_slot_q   <= SLOT_W'(SLOTS / 4);
							slot_filled_q  <= '0;
							filled_count_q <= '0;
						end
						if (read_play) begin
							state_q <= ST_MEM;
							// frame played out: advance the ring, release the slot
							if (e.is_last) begin
								read_slot_q  <= read_slot_q + 1'b1;
								write_slot_q <= write_slot_q + 1'b1;
								if (slot_filled_q[read_slot_q]) begin
									filled_count_q <= filled_count_q - 1'b1;
								end
								slot_filled_q[read_slot_q] <= 1'b0;
							end
						end else begin
							out_valid_q <= 1'b1;
							state_q     <= reseq_now ? ST_CLEAR : ST_IDLE;
						end
					end
				end
				ST_MEM: begin
					if (op_q == OP_READ) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// item payload and result register
	always_ff @(posedge clk) begin
		if (take) begin
			op_q   <= e.opcode;
			slot_q <= use_slot;
			addr_q <= item_addr;
			b_q    <= e.sample;
			last_q <= e.is_last;
			if (is_post || !read_play) begin
				out_q.out_sample <= '0;
				out_q.slot       <= 4'(use_slot);
				out_q.silent     <= !is_post;
				out_q.rejected   <= is_post && post_rej;
				out_q.last       <= e.is_last;
			end
		end
		if (state_q == ST_MEM && op_q == OP_READ) begin
			out_q.out_sample <= rdata_s1;
			out_q.slot       <= 4'(slot_q);
			out_q.silent     <= 1'b0;
			out_q.rejected   <= 1'b0;
			out_q.last       <= last_q;
		end
	end

	// multiply stage of the mixer
	always_ff @(posedge clk) begin
		if (state_q == ST_MEM) begin
			a_s2    <= rdata_s1;
			prod_s2 <= rdata_s1 * b_q;
		end
	end

	// frame memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem_q[item_addr];
	end

endmodule
`default_nettype wire
